[src/lsp_pkg.sv]
`default_nettype none
package lsp_pkg;

    // Geometry of the sample store and fixed-point formats
    localparam int MAX_FRAMES = 65536;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = FRAME_W + 1;
    localparam int FRAC_W     = 16;
    localparam int POS_W      = COUNT_W + FRAC_W;
    localparam int SAMPLE_W   = 16;
    localparam int GAIN_W     = 17;
    localparam int SPEED_W    = 19;
    localparam int CMD_W      = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 19;

    localparam logic [GAIN_W-1:0]  GAIN_UNITY = 17'd65536;
    localparam logic [SPEED_W-1:0] SPEED_MIN  = 19'd16384;
    localparam logic [SPEED_W-1:0] SPEED_MAX  = 19'd262144;

    // Request word commands
    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_PLAY  = 2'd1,
        CMD_STOP  = 2'd2,
        CMD_TICK  = 2'd3
    } cmd_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_START = 3'd0,
        REG_REGION_END   = 3'd1,
        REG_CLIP_FRAMES  = 3'd2,
        REG_LOOP_ENABLE  = 3'd3,
        REG_GAIN         = 3'd4,
        REG_SPEED_STEP   = 3'd5,
        REG_MONO_OUT     = 3'd6,
        REG_STEREO_CLIP  = 3'd7
    } cfg_idx_t;

    // Clamped playback settings seen by the datapath
    typedef struct packed {
        logic [FRAME_W-1:0] rgn_start;
        logic [COUNT_W-1:0] rgn_end;
        logic [COUNT_W-1:0] rgn_span;
        logic               clip_loaded;
        logic               loop_en;
        logic [GAIN_W-1:0]  gain;
        logic [SPEED_W-1:0] speed;
        logic               mono;
        logic               stereo;
    } play_cfg_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_MULD,
        ST_INTERP,
        ST_MULG,
        ST_ADV,
        ST_WRAP,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic rd0;
        logic rd1;
        logic muld;
        logic interp;
        logic mulg;
        logic adv;
        logic wrap;
        logic emit;
    } dp_ctl_t;

    // Datapath to controller status
    typedef struct packed {
        logic tick_run;
        logic wrap_pending;
        logic out_free;
    } dp_sts_t;

endpackage
`default_nettype wire

[src/lsp_req_if.sv]
`default_nettype none
interface lsp_req_if;
    import lsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [CMD_W-1:0]           command;
    logic [FRAME_W-1:0]         frame_index;
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;

    modport source (output valid, command, frame_index, sample_left, sample_right,
                    input ready);
    modport sink   (input valid, command, frame_index, sample_left, sample_right,
                    output ready);
endinterface
`default_nettype wire

[src/lsp_res_if.sv]
`default_nettype none
interface lsp_res_if;
    import lsp_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       playing;
    logic [COUNT_W-1:0]         position_frame;

    modport source (output valid, left_out, right_out, playing, position_frame,
                    input ready);
    modport sink   (input valid, left_out, right_out, playing, position_frame,
                    output ready);
endinterface
`default_nettype wire

[src/looping_sample_player.sv]
`default_nettype none
// Channel   Dir  Payload                                            Word
// request   in   command, frame_index, sample_left, sample_right   one command
// result    out  left_out, right_out, playing, position_frame      one frame per tick
// cfg_*     in   cfg_we, cfg_index, cfg_data                        one register write
//
// Write, play and stop are taken in the idle state. A tick while stopped goes
// straight to emit; a playing tick steps through two reads of the single-port
// sample store, two multiply stages and a wrap loop of one subtract a cycle.
// Reset clears position and run flag; sample store contents are undefined.
// A finished frame waits in the output register while the next word is taken;
// a tick stalls in its last step only when that register is still full.
module looping_sample_player (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    lsp_req_if.sink                             request,
    lsp_res_if.source                           result,
    input  wire logic                           cfg_we,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lsp_pkg::*;

    play_cfg_t cfg;
    dp_ctl_t   ctl;
    dp_sts_t   sts;
    logic      req_ready;

    // Configuration registers
    lsp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Sequencer
    lsp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (request.valid),
        .req_command (request.command),
        .req_ready   (req_ready),
        .sts         (sts),
        .ctl         (ctl)
    );

    // Sample store and arithmetic
    lsp_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctl            (ctl),
        .sts            (sts),
        .cfg            (cfg),
        .command        (request.command),
        .frame_index    (request.frame_index),
        .sample_left    (request.sample_left),
        .sample_right   (request.sample_right),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .left_out       (result.left_out),
        .right_out      (result.right_out),
        .playing        (result.playing),
        .position_frame (result.position_frame)
    );

    assign request.ready = req_ready;

endmodule
`default_nettype wire

[src/lsp_cfg.sv]
`default_nettype none
module lsp_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [lsp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [lsp_pkg::CFG_DATA_W-1:0] cfg_data,
    output lsp_pkg::play_cfg_t                  cfg
);
    import lsp_pkg::*;

    logic [FRAME_W-1:0] rs_reg;
    logic [COUNT_W-1:0] re_reg;
    logic [COUNT_W-1:0] clip_reg;
    logic               loop_reg;
    logic [GAIN_W-1:0]  gain_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic               mono_reg;
    logic               stereo_reg;

    logic [COUNT_W-1:0] frames;
    logic [COUNT_W-1:0] frames_m1;
    logic               short_clip;
    logic [FRAME_W-1:0] start_c;
    logic [COUNT_W-1:0] start_p1;
    logic [COUNT_W-1:0] end_c;

    // Register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rs_reg     <= '0;
            re_reg     <= COUNT_W'(1);
            clip_reg   <= '0;
            loop_reg   <= 1'b0;
            gain_reg   <= GAIN_W'(16384);
            speed_reg  <= SPEED_W'(65536);
            mono_reg   <= 1'b0;
            stereo_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_START: rs_reg     <= cfg_data[FRAME_W-1:0];
                REG_REGION_END:   re_reg     <= cfg_data[COUNT_W-1:0];
                REG_CLIP_FRAMES:  clip_reg   <= cfg_data[COUNT_W-1:0];
                REG_LOOP_ENABLE:  loop_reg   <= cfg_data[0];
                REG_GAIN:         gain_reg   <= cfg_data[GAIN_W-1:0];
                REG_SPEED_STEP:   speed_reg  <= cfg_data[SPEED_W-1:0];
                REG_MONO_OUT:     mono_reg   <= cfg_data[0];
                REG_STEREO_CLIP:  stereo_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    // Region clamp against the loaded clip
    always_comb
    begin
        frames     = (clip_reg > COUNT_W'(MAX_FRAMES)) ? COUNT_W'(MAX_FRAMES) : clip_reg;
        frames_m1  = frames - COUNT_W'(1);
        short_clip = (frames <= COUNT_W'(1));
        if (short_clip)
            start_c = '0;
        else if ({1'b0, rs_reg} > frames_m1)
            start_c = frames_m1[FRAME_W-1:0];
        else
            start_c = rs_reg;
        start_p1 = {1'b0, start_c} + COUNT_W'(1);
        if (short_clip)
            end_c = COUNT_W'(1);
        else if (re_reg < start_p1)
            end_c = start_p1;
        else if (re_reg > frames)
            end_c = frames;
        else
            end_c = re_reg;
    end

    // Clamped settings
    always_comb
    begin
        cfg.rgn_start   = start_c;
        cfg.rgn_end     = end_c;
        cfg.rgn_span    = end_c - {1'b0, start_c};
        cfg.clip_loaded = (frames != '0);
        cfg.loop_en     = loop_reg;
        cfg.gain        = (gain_reg > GAIN_UNITY) ? GAIN_UNITY : gain_reg;
        if (speed_reg < SPEED_MIN)
            cfg.speed = SPEED_MIN;
        else if (speed_reg > SPEED_MAX)
            cfg.speed = SPEED_MAX;
        else
            cfg.speed = speed_reg;
        cfg.mono   = mono_reg;
        cfg.stereo = stereo_reg;
    end

endmodule
`default_nettype wire

[src/lsp_ctrl.sv]
`default_nettype none
module lsp_ctrl (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      req_valid,
    input  wire logic [lsp_pkg::CMD_W-1:0] req_command,
    output logic                           req_ready,
    input  lsp_pkg::dp_sts_t               sts,
    output lsp_pkg::dp_ctl_t               ctl
);
    import lsp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && (req_command == CMD_TICK))
                    state_next = sts.tick_run ? ST_RD0 : ST_EMIT;
            end
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_MULD;
            ST_MULD:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_MULG;
            ST_MULG:   state_next = ST_ADV;
            ST_ADV:    state_next = ST_WRAP;
            ST_WRAP:
            begin
                if (!sts.wrap_pending)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath commands
    always_comb
    begin
        ctl       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready  = 1'b1;
                ctl.accept = req_valid;
            end
            ST_RD0:    ctl.rd0    = 1'b1;
            ST_RD1:    ctl.rd1    = 1'b1;
            ST_MULD:   ctl.muld   = 1'b1;
            ST_INTERP: ctl.interp = 1'b1;
            ST_MULG:   ctl.mulg   = 1'b1;
            ST_ADV:    ctl.adv    = 1'b1;
            ST_WRAP:   ctl.wrap   = sts.wrap_pending;
            ST_EMIT:   ctl.emit   = sts.out_free;
            default:   ;
        endcase
    end

endmodule
`default_nettype wire

[src/lsp_dp.sv]
`default_nettype none
module lsp_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  lsp_pkg::dp_ctl_t                         ctl,
    output lsp_pkg::dp_sts_t                         sts,
    input  lsp_pkg::play_cfg_t                       cfg,
    input  wire logic [lsp_pkg::CMD_W-1:0]           command,
    input  wire logic [lsp_pkg::FRAME_W-1:0]         frame_index,
    input  wire logic signed [lsp_pkg::SAMPLE_W-1:0] sample_left,
    input  wire logic signed [lsp_pkg::SAMPLE_W-1:0] sample_right,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic signed [lsp_pkg::SAMPLE_W-1:0]      left_out,
    output logic signed [lsp_pkg::SAMPLE_W-1:0]      right_out,
    output logic                                     playing,
    output logic [lsp_pkg::COUNT_W-1:0]              position_frame
);
    import lsp_pkg::*;

    localparam int WORD_W = 2 * SAMPLE_W;
    localparam int DIFF_W = SAMPLE_W + 1;
    localparam int PD_W   = 2 * SAMPLE_W + 2;
    localparam int GP_W   = SAMPLE_W + GAIN_W + 2;

    // Clamp a rounded product to the signed sample range
    function automatic logic [SAMPLE_W-1:0] sat_sample(input logic signed [GP_W-1:0] v);
        logic signed [GP_W-1:0] hi;
        logic signed [GP_W-1:0] lo;
        hi = GP_W'((1 << (SAMPLE_W - 1)) - 1);
        lo = -hi - GP_W'(1);
        if (v > hi)
            sat_sample = hi[SAMPLE_W-1:0];
        else if (v < lo)
            sat_sample = lo[SAMPLE_W-1:0];
        else
            sat_sample = v[SAMPLE_W-1:0];
    endfunction

    // Sample store: left in the upper half of each word
    logic [WORD_W-1:0]  mem [MAX_FRAMES];
    logic [WORD_W-1:0]  mem_q;
    logic               mem_we;
    logic [FRAME_W-1:0] rd_addr;

    // Control state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic             running_reg, running_next;
    logic             out_valid_reg, out_valid_next;

    // Work registers
    logic [FRAME_W-1:0]         i1_reg;
    logic [WORD_W-1:0]          a_reg;
    logic signed [PD_W-1:0]     pd_l_reg, pd_r_reg;
    logic signed [SAMPLE_W-1:0] l_reg, r_reg;
    logic signed [GP_W-1:0]     gp_l_reg, gp_r_reg;
    logic [SAMPLE_W-1:0]        lo_reg, ro_reg;
    logic [SAMPLE_W-1:0]        left_reg, right_reg;
    logic                       playing_reg;
    logic [COUNT_W-1:0]         posf_reg;

    // Combinational terms
    logic [POS_W-1:0]           start_pos, end_pos, span_pos, pos_sum;
    logic                       out_of_region;
    logic [FRAME_W-1:0]         i0;
    logic [COUNT_W-1:0]         i0_inc, end_m1;
    logic [FRAME_W-1:0]         i1_next;
    logic [FRAC_W-1:0]          frac;
    logic signed [DIFF_W-1:0]   diff_l, diff_r, frac_s;
    logic signed [PD_W-1:0]     prod_l, prod_r;
    logic signed [PD_W-1:0]     rnd_l, rnd_r;
    logic signed [SAMPLE_W-1:0] l_next, r_next;
    logic signed [DIFF_W-1:0]   op_l;
    logic signed [GAIN_W:0]     g_s;
    logic signed [GP_W-1:0]     gp_l, gp_r, res_l, res_r;
    logic [SAMPLE_W-1:0]        sat_l, sat_r;

    assign mem_we  = ctl.accept && (command == CMD_WRITE);
    assign rd_addr = ctl.rd1 ? i1_reg : pos_reg[FRAC_W +: FRAME_W];

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[frame_index] <= {sample_left, sample_right};
        mem_q <= mem[rd_addr];
    end

    // Region bounds in position units
    assign start_pos     = POS_W'({cfg.rgn_start, {FRAC_W{1'b0}}});
    assign end_pos       = {cfg.rgn_end, {FRAC_W{1'b0}}};
    assign span_pos      = {cfg.rgn_span, {FRAC_W{1'b0}}};
    assign out_of_region = (pos_reg < start_pos) || (pos_reg >= end_pos);
    assign pos_sum       = pos_reg + POS_W'(cfg.speed);

    // Neighbor frame index: wrap to start or hold the last frame
    assign i0     = pos_reg[FRAC_W +: FRAME_W];
    assign frac   = pos_reg[FRAC_W-1:0];
    assign i0_inc = {1'b0, i0} + COUNT_W'(1);
    assign end_m1 = cfg.rgn_end - COUNT_W'(1);
    assign i1_next = (i0_inc >= cfg.rgn_end)
                   ? (cfg.loop_en ? cfg.rgn_start : end_m1[FRAME_W-1:0])
                   : i0_inc[FRAME_W-1:0];

    // Difference times fraction
    always_comb
    begin
        diff_l = $signed({mem_q[WORD_W-1], mem_q[WORD_W-1 -: SAMPLE_W]})
               - $signed({a_reg[WORD_W-1], a_reg[WORD_W-1 -: SAMPLE_W]});
        diff_r = $signed({mem_q[SAMPLE_W-1], mem_q[SAMPLE_W-1:0]})
               - $signed({a_reg[SAMPLE_W-1], a_reg[SAMPLE_W-1:0]});
        frac_s = $signed({1'b0, frac});
        prod_l = diff_l * frac_s;
        prod_r = diff_r * frac_s;
    end

    // Round and add to the base frame
    always_comb
    begin
        rnd_l  = (pd_l_reg + PD_W'(32768)) >>> FRAC_W;
        rnd_r  = (pd_r_reg + PD_W'(32768)) >>> FRAC_W;
        l_next = a_reg[WORD_W-1 -: SAMPLE_W] + rnd_l[SAMPLE_W-1:0];
        r_next = cfg.stereo ? (a_reg[SAMPLE_W-1:0] + rnd_r[SAMPLE_W-1:0]) : l_next;
    end

    // Gain products; mono uses the channel sum
    always_comb
    begin
        g_s  = $signed({1'b0, cfg.gain});
        op_l = cfg.mono ? (DIFF_W'(l_reg) + DIFF_W'(r_reg)) : DIFF_W'(l_reg);
        gp_l = op_l * g_s;
        gp_r = r_reg * g_s;
    end

    // Rounding shift and saturation
    always_comb
    begin
        if (cfg.mono)
            res_l = (gp_l_reg + GP_W'(65536)) >>> (FRAC_W + 1);
        else
            res_l = (gp_l_reg + GP_W'(32768)) >>> FRAC_W;
        res_r = (gp_r_reg + GP_W'(32768)) >>> FRAC_W;
        sat_l = sat_sample(res_l);
        sat_r = cfg.mono ? sat_l : sat_sample(res_r);
    end

    // Position, run flag and result valid
    always_comb
    begin
        pos_next       = pos_reg;
        running_next   = running_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (ctl.emit)
            out_valid_next = 1'b1;
        if (ctl.accept)
        begin
            case (command)
                CMD_WRITE:
                begin
                    running_next = 1'b0;
                    pos_next     = '0;
                end
                CMD_PLAY:
                begin
                    running_next = cfg.clip_loaded;
                    if (cfg.clip_loaded)
                        pos_next = start_pos;
                end
                CMD_STOP: running_next = 1'b0;
                CMD_TICK:
                begin
                    if (!cfg.clip_loaded)
                        running_next = 1'b0;
                    else if (running_reg && out_of_region)
                        pos_next = start_pos;
                end
                default: ;
            endcase
        end
        if (ctl.adv)
        begin
            pos_next = pos_sum;
            if ((pos_sum >= end_pos) && !cfg.loop_en)
                running_next = 1'b0;
        end
        if (ctl.wrap)
            pos_next = pos_reg - span_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            running_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            running_reg   <= running_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Pipeline payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.rd0)
            i1_reg <= i1_next;
        if (ctl.rd1)
            a_reg <= mem_q;
        if (ctl.muld)
        begin
            pd_l_reg <= prod_l;
            pd_r_reg <= prod_r;
        end
        if (ctl.interp)
        begin
            l_reg <= l_next;
            r_reg <= r_next;
        end
        if (ctl.mulg)
        begin
            gp_l_reg <= gp_l;
            gp_r_reg <= gp_r;
        end
        if (ctl.accept)
        begin
            lo_reg <= '0;
            ro_reg <= '0;
        end
        else if (ctl.adv)
        begin
            lo_reg <= sat_l;
            ro_reg <= sat_r;
        end
        if (ctl.emit)
        begin
            left_reg    <= lo_reg;
            right_reg   <= ro_reg;
            playing_reg <= running_reg;
            posf_reg    <= pos_reg[FRAC_W +: COUNT_W];
        end
    end

    assign sts.tick_run     = running_reg && cfg.clip_loaded;
    assign sts.wrap_pending = cfg.loop_en && (pos_reg >= end_pos);
    assign sts.out_free     = !out_valid_reg || out_ready;

    assign out_valid      = out_valid_reg;
    assign left_out       = left_reg;
    assign right_out      = right_reg;
    assign playing        = playing_reg;
    assign position_frame = posf_reg;

endmodule
`default_nettype wire

[dv/lsp_frame_check_pkg.sv]
package lsp_frame_check_pkg;
    import lsp_pkg::*;

    // One output frame as seen on the result channel
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left;
        logic signed [SAMPLE_W-1:0] right;
        logic                       playing;
        logic [COUNT_W-1:0]         frame;
    } out_frame_t;

    // Tracks the player's state, predicts every tick frame and checks the
    // frames that come back, oldest first.
    class frame_scoreboard;
        logic signed [SAMPLE_W-1:0] left_mem  [MAX_FRAMES];
        logic signed [SAMPLE_W-1:0] right_mem [MAX_FRAMES];
        bit                         loaded    [MAX_FRAMES];

        logic [FRAME_W-1:0] rgn_start;
        logic [COUNT_W-1:0] rgn_end;
        logic [COUNT_W-1:0] clip_frames;
        logic               loop_en;
        logic [GAIN_W-1:0]  gain;
        logic [SPEED_W-1:0] speed;
        logic               mono;
        logic               stereo;

        longint     position;
        bit         running;
        out_frame_t expected_frames[$];
        int         errors;

        function new();
            rgn_start   = '0;
            rgn_end     = 1;
            clip_frames = 0;
            loop_en     = 1'b0;
            gain        = 16384;
            speed       = 65536;
            mono        = 1'b0;
            stereo      = 1'b1;
            position    = 0;
            running     = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void set_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_REGION_START: rgn_start   = data[FRAME_W-1:0];
                REG_REGION_END:   rgn_end     = data[COUNT_W-1:0];
                REG_CLIP_FRAMES:  clip_frames = data[COUNT_W-1:0];
                REG_LOOP_ENABLE:  loop_en     = data[0];
                REG_GAIN:         gain        = data[GAIN_W-1:0];
                REG_SPEED_STEP:   speed       = data[SPEED_W-1:0];
                REG_MONO_OUT:     mono        = data[0];
                REG_STEREO_CLIP:  stereo      = data[0];
                default: ;
            endcase
        endfunction

        function longint frames_held();
            return (clip_frames > MAX_FRAMES) ? MAX_FRAMES : clip_frames;
        endfunction

        // Region after clamping to the clip; a clip of at most one frame plays 0..1
        function void play_region(output longint first, output longint last_excl);
            longint t;
            t = frames_held();
            if (t <= 1)
            begin
                first     = 0;
                last_excl = 1;
            end
            else
            begin
                first = (rgn_start > t - 1) ? t - 1 : longint'(rgn_start);
                if (rgn_end < first + 1)
                    last_excl = first + 1;
                else if (rgn_end > t)
                    last_excl = t;
                else
                    last_excl = rgn_end;
            end
        endfunction

        // Round half up, then divide by 2^k
        static function longint round_shift(longint x, int k);
            return (x + (longint'(1) << (k - 1))) >>> k;
        endfunction

        static function longint clip_sample(longint v);
            if (v > 32767)
                return 32767;
            if (v < -32768)
                return -32768;
            return v;
        endfunction

        static function longint blend(longint a, longint b, longint frac);
            return a + round_shift((b - a) * frac, 16);
        endfunction

        // Output frame of one tick; advances the play head
        function out_frame_t next_frame();
            longint     first, last_excl, i0, i1, frac, l, r, g, step, lo, ro;
            out_frame_t f;
            lo = 0;
            ro = 0;
            if (frames_held() == 0)
                running = 1'b0;
            if (running)
            begin
                play_region(first, last_excl);
                if (position < (first << FRAC_W) || position >= (last_excl << FRAC_W))
                    position = first << FRAC_W;
                i0 = position >>> FRAC_W;
                if (i0 < first)
                    i0 = first;
                if (i0 > last_excl - 1)
                    i0 = last_excl - 1;
                i1 = i0 + 1;
                if (i1 >= last_excl)
                    i1 = loop_en ? first : last_excl - 1;
                frac = (position - (i0 << FRAC_W)) & 65535;

                l = blend(left_mem[i0], left_mem[i1], frac);
                r = stereo ? blend(right_mem[i0], right_mem[i1], frac) : l;

                g = (gain > GAIN_UNITY) ? longint'(GAIN_UNITY) : longint'(gain);
                if (mono)
                begin
                    lo = clip_sample(round_shift((l + r) * g, 17));
                    ro = lo;
                end
                else
                begin
                    lo = clip_sample(round_shift(l * g, 16));
                    ro = clip_sample(round_shift(r * g, 16));
                end

                // Step clamped to 0.25..4 frames
                if (speed < SPEED_MIN)
                    step = SPEED_MIN;
                else if (speed > SPEED_MAX)
                    step = SPEED_MAX;
                else
                    step = speed;
                position += step;
                if (position >= (last_excl << FRAC_W))
                begin
                    if (loop_en)
                    begin
                        while (position >= (last_excl << FRAC_W))
                            position -= (last_excl - first) << FRAC_W;
                        if (position < (first << FRAC_W))
                            position = first << FRAC_W;
                    end
                    else
                        running = 1'b0;
                end
            end
            f.left    = lo[SAMPLE_W-1:0];
            f.right   = ro[SAMPLE_W-1:0];
            f.playing = running;
            f.frame   = position[FRAC_W +: COUNT_W];
            return f;
        endfunction

        // Accepted request word
        function void note_command(cmd_t cmd, logic [FRAME_W-1:0] index,
                                   logic signed [SAMPLE_W-1:0] l,
                                   logic signed [SAMPLE_W-1:0] r);
            longint first, last_excl;
            case (cmd)
                CMD_WRITE:
                begin
                    left_mem[index]  = l;
                    right_mem[index] = r;
                    loaded[index]    = 1'b1;
                    running          = 1'b0;
                    position         = 0;
                end
                CMD_PLAY:
                begin
                    if (frames_held() == 0)
                        running = 1'b0;
                    else
                    begin
                        play_region(first, last_excl);
                        position = first << FRAC_W;
                        running  = 1'b1;
                    end
                end
                CMD_STOP: running = 1'b0;
                default:  expected_frames.push_back(next_frame());
            endcase
        endfunction

        task report(string what);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", what);
        endtask

        task check_frame(out_frame_t got);
            out_frame_t want;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected frame L=%0d R=%0d playing=%0b pos=%0d",
                                 got.left, got.right, got.playing, got.frame));
                return;
            end
            want = expected_frames.pop_front();
            if (got.left !== want.left || got.right !== want.right ||
                got.playing !== want.playing || got.frame !== want.frame)
                report($sformatf("frame L=%0d R=%0d playing=%0b pos=%0d, want L=%0d R=%0d playing=%0b pos=%0d",
                                 got.left, got.right, got.playing, got.frame,
                                 want.left, want.right, want.playing, want.frame));
        endtask
    endclass

endpackage

[dv/looping_sample_player_test.sv]
module looping_sample_player_test;
    import lsp_pkg::*;
    import lsp_frame_check_pkg::*;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lsp_req_if request_ch();
    lsp_res_if result_ch();

    looping_sample_player dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    frame_scoreboard sb;
    bit              calm;
    bit              primed;
    int              words_sent;
    int unsigned     last_base;
    int unsigned     last_span;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial
    begin
        #30000000;
        $display("[looping_sample_player] ERROR");
        $finish;
    end

    // Idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int unsigned pick;
        if (calm)
            return 0;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [SAMPLE_W-1:0] rand_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            return 16'h7FFF;
        if (pick < 20)
            return 16'h8000;
        if (pick < 25)
            return 16'h0000;
        return $urandom;
    endfunction

    // One request word; payload of non-write words is junk the block must ignore
    task automatic send_word(cmd_t cmd, logic [FRAME_W-1:0] index = '0,
                             logic [SAMPLE_W-1:0] l = '0, logic [SAMPLE_W-1:0] r = '0);
        int gap;
        gap = idle_len();
        if (cmd != CMD_WRITE)
        begin
            index = $urandom;
            l     = $urandom;
            r     = $urandom;
        end
        repeat (gap)
        begin
            @(negedge clk);
            request_ch.valid = 1'b0;
        end
        @(negedge clk);
        request_ch.valid        = 1'b1;
        request_ch.command      = cmd;
        request_ch.frame_index  = index;
        request_ch.sample_left  = l;
        request_ch.sample_right = r;
        do
            @(posedge clk);
        while (request_ch.ready !== 1'b1);
        sb.note_command(cmd, index, l, r);
        words_sent++;
    endtask

    task automatic set_reg(cfg_idx_t idx, int unsigned value);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value[CFG_DATA_W-1:0];
        @(posedge clk);
        sb.set_register(idx, cfg_data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Drop valid, wait for every frame, then let a trailing tick finish
    task automatic settle();
        @(negedge clk);
        request_ch.valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic run_directed();
        // Empty clip: play acts as stop, ticks give silence
        send_word(CMD_TICK);
        send_word(CMD_PLAY);
        send_word(CMD_TICK);
        // Frames at both ends of the store, some of them full scale
        send_word(CMD_WRITE, 16'h0000, 16'h7FFF, 16'h8000);
        send_word(CMD_WRITE, 16'h0001, 16'h8000, 16'h7FFF);
        send_word(CMD_WRITE, 16'h0002, 16'hFFFF, 16'h0001);
        send_word(CMD_WRITE, 16'hFFFF, 16'h8000, 16'h7FFF);
        send_word(CMD_WRITE, 16'hFFFE, 16'h3039, 16'hA460);
        settle();

        // Quarter-frame steps (step below minimum) across opposite full scale
        set_reg(REG_CLIP_FRAMES, 3);
        set_reg(REG_REGION_START, 0);
        set_reg(REG_REGION_END, 3);
        set_reg(REG_LOOP_ENABLE, 1);
        set_reg(REG_GAIN, 65536);
        set_reg(REG_SPEED_STEP, 0);
        send_word(CMD_PLAY);
        repeat (4) send_word(CMD_TICK);
        settle();

        // Top of the store: oversized clip, step and gain; mono mix, wrap
        set_reg(REG_CLIP_FRAMES, 131071);
        set_reg(REG_REGION_START, 65534);
        set_reg(REG_REGION_END, 131071);
        set_reg(REG_SPEED_STEP, 524287);
        set_reg(REG_GAIN, 131071);
        set_reg(REG_MONO_OUT, 1);
        send_word(CMD_PLAY);
        repeat (2) send_word(CMD_TICK);
        settle();

        // Still running: with loop off it runs past the end and stops
        set_reg(REG_LOOP_ENABLE, 0);
        set_reg(REG_SPEED_STEP, 100000);
        repeat (3) send_word(CMD_TICK);
        settle();

        // One-frame clip read as mono, start clamped down
        set_reg(REG_CLIP_FRAMES, 1);
        set_reg(REG_REGION_START, 5);
        set_reg(REG_STEREO_CLIP, 0);
        set_reg(REG_MONO_OUT, 0);
        set_reg(REG_LOOP_ENABLE, 1);
        set_reg(REG_GAIN, 40000);
        send_word(CMD_PLAY);
        send_word(CMD_TICK);
        settle();

        // Region moved while running: head snaps to the new start
        set_reg(REG_CLIP_FRAMES, 3);
        set_reg(REG_REGION_START, 2);
        set_reg(REG_REGION_END, 0);
        send_word(CMD_TICK);
        send_word(CMD_STOP);
        send_word(CMD_TICK);
        settle();
        last_base = 2;
        last_span = 1;
    endtask

    // New settings, load whatever the region lacks, then play it
    task automatic run_phase();
        int unsigned base, span, pick, count, chance, value;
        longint      first, last_excl;
        settle();
        calm   = ($urandom_range(0, 5) == 0);
        chance = primed ? 60 : 100;
        primed = 1'b1;

        pick = $urandom_range(0, 99);
        if (pick < 25 && last_span > 1)
        begin
            base = last_base + $urandom_range(0, last_span - 1);
            span = $urandom_range(1, last_base + last_span - base);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                span = $urandom_range(2, 24);
            else if (pick < 92)
                span = 1;
            else
                span = $urandom_range(25, 200);
            pick = $urandom_range(0, 99);
            if (pick < 10)
                base = 0;
            else if (pick < 20)
                base = 65536 - span;
            else
                base = $urandom_range(0, 65536 - span);
        end

        if ($urandom_range(0, 99) < chance)
            set_reg(REG_REGION_START,
                    ($urandom_range(0, 99) < 90) ? base : $urandom_range(0, 65535));
        if ($urandom_range(0, 99) < chance)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 75)
                value = base + span;
            else if (pick < 83)
                value = 0;
            else
                value = $urandom_range(0, 131071);
            set_reg(REG_REGION_END, value);
        end
        if ($urandom_range(0, 99) < chance)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                value = base + span;
            else if (pick < 70)
                value = 65536;
            else if (pick < 85)
                value = $urandom_range(base + span, 131071);
            else if (pick < 90)
                value = 0;
            else if (pick < 95)
                value = 1;
            else
                value = $urandom_range(0, 65536);
            set_reg(REG_CLIP_FRAMES, value);
        end
        if ($urandom_range(0, 99) < chance)
            set_reg(REG_LOOP_ENABLE, $urandom_range(0, 1));
        if ($urandom_range(0, 99) < chance)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                value = 65536;
            else if (pick < 25)
                value = 0;
            else if (pick < 40)
                value = $urandom_range(0, 131071);
            else
                value = $urandom_range(0, 65536);
            set_reg(REG_GAIN, value);
        end
        if ($urandom_range(0, 99) < chance)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                value = 16384;
            else if (pick < 20)
                value = 262144;
            else if (pick < 25)
                value = $urandom_range(0, 16383);
            else if (pick < 30)
                value = $urandom_range(262145, 524287);
            else
                value = $urandom_range(16384, 262144);
            set_reg(REG_SPEED_STEP, value);
        end
        if ($urandom_range(0, 99) < chance)
            set_reg(REG_MONO_OUT, $urandom_range(0, 1));
        if ($urandom_range(0, 99) < chance)
            set_reg(REG_STEREO_CLIP, $urandom_range(0, 1));

        // Keep the clamped region short enough to load
        sb.play_region(first, last_excl);
        if (last_excl - first > 256)
        begin
            set_reg(REG_REGION_END, int'(first) + span);
            sb.play_region(first, last_excl);
        end
        last_base = first;
        last_span = last_excl - first;

        // Every frame the region can read must hold data
        for (longint k = first; k < last_excl; k++)
            if (!sb.loaded[k])
                send_word(CMD_WRITE, k, rand_sample(), rand_sample());

        count = $urandom_range(6, 40);
        if ($urandom_range(0, 9) != 0)
            send_word(CMD_PLAY);
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
                send_word(CMD_TICK);
            else if (pick < 86)
                send_word(CMD_PLAY);
            else if (pick < 91)
                send_word(CMD_STOP);
            else if (pick < 96)
                send_word(CMD_WRITE, $urandom, rand_sample(), rand_sample());
            else
                send_word(CMD_WRITE, last_base + $urandom_range(0, last_span - 1),
                          rand_sample(), rand_sample());
        end
    endtask

    // Result side back-pressure
    initial
    begin
        int hold;
        int stall;
        hold = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold > 0)
                hold--;
            else
            begin
                stall = idle_len();
                if (stall == 0)
                begin
                    result_ch.ready = 1'b1;
                    hold = $urandom_range(0, 5);
                end
                else
                begin
                    result_ch.ready = 1'b0;
                    hold = stall - 1;
                end
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            sb.check_frame(out_frame_t'{result_ch.left_out, result_ch.right_out,
                                        result_ch.playing, result_ch.position_frame});
    end

    initial
    begin
        sb         = new();
        calm       = 1'b0;
        primed     = 1'b0;
        words_sent = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        request_ch.valid        = 1'b0;
        request_ch.command      = CMD_WRITE;
        request_ch.frame_index  = '0;
        request_ch.sample_left  = '0;
        request_ch.sample_right = '0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        run_directed();
        while (words_sent < 1425)
            run_phase();
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("[looping_sample_player] OK");
        else
            $display("[looping_sample_player] ERROR");
        $finish;
    end

endmodule
